### rtl/mbt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 2-2-1 backpropagation trainer.
// No dependencies; used by mbt_mul and the top level.
package mbt_pkg;

  localparam int OPW   = 20;        // datapath operand width
  localparam int PW    = 2 * OPW;   // full product width
  localparam int NW    = 6;         // number of weights
  localparam int CIW   = 3;         // register index width
  localparam int DLW   = 24;        // delta sum width

  localparam logic [CIW-1:0] REG_LEARN_RATE = 3'd0;
  localparam logic [CIW-1:0] REG_INIT_LAST  = 3'd6;

  typedef enum logic [1:0] {
    SH_FRAC,
    SH_FRAC1,
    SH_16
  } shift_e;

  typedef struct packed {
    logic signed [OPW-1:0] opa;
    logic signed [OPW-1:0] opb;
    shift_e                sh;
  } mul_req_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_X0, ST_X1,
    ST_H0A, ST_H0B, ST_H0S, ST_H1A, ST_H1B, ST_H1S,
    ST_OA, ST_OB, ST_OS,
    ST_SE, ST_G1, ST_G2,
    ST_A4V, ST_A4D, ST_A5V, ST_A5D,
    ST_J0W, ST_J0H, ST_J0D, ST_A0V, ST_A0D, ST_A1V, ST_A1D,
    ST_J1W, ST_J1H, ST_J1D, ST_A2V, ST_A2D, ST_A3V, ST_A3D,
    ST_UPD, ST_DONE
  } step_e;

  // Unsigned quotient by shift and subtract; elaboration only.
  function automatic longint udiv(input longint a, input longint b);
    longint q, r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r << 1) | ((a >> i) & longint'(1));
      if (r >= b) begin
        r = r - b;
        q = q | (longint'(1) << i);
      end
    end
    return q;
  endfunction

  // Sigmoid at the centre of slice k, rounded to frac fraction bits.
  // Elaboration only: Q30 integer arithmetic.
  function automatic longint sig_entry(input longint k, input longint n,
                                       input longint frac);
    longint q30, c, mag, t30, fr, nn, sum, term, e, den, num, i;
    q30  = longint'(1) << 30;
    c    = udiv((2 * k + 1) * 65536, 2 * n) - 32768;
    mag  = (c < 0) ? -c : c;
    t30  = mag << (30 - frac);
    fr   = t30 & (q30 - 1);
    nn   = t30 >> 30;
    sum  = q30;
    term = q30;
    for (i = 1; i <= 20; i++) begin
      term = udiv((term * fr) >> 30, i);
      if (i[0]) sum = sum - term;
      else sum = sum + term;
    end
    for (i = 0; i < nn; i++) begin
      sum = (sum * 395007542 + (q30 >> 1)) >> 30;
    end
    e   = sum;
    den = q30 + e;
    num = (c >= 0) ? (longint'(1) << frac) * q30 : (longint'(1) << frac) * e;
    return udiv(num + (den >> 1), den);
  endfunction

endpackage

### rtl/mbt_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with round-half-up rescale.
// Depends on mbt_pkg.
module mbt_mul #(
  parameter int FRAC_BITS = 12
) (
  input  mbt_pkg::mul_req_t               req_i,
  output logic signed [mbt_pkg::PW-1:0]   prod_o,
  output logic signed [mbt_pkg::OPW-1:0]  res_o
);
  import mbt_pkg::*;

  logic signed [PW-1:0] r_frac, r_frac1, r_16;

  assign prod_o  = PW'(req_i.opa) * PW'(req_i.opb);
  assign r_frac  = (prod_o + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign r_frac1 = (prod_o + (PW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
  assign r_16    = (prod_o + (PW'(1) <<< 15)) >>> 16;

  always_comb begin
    case (req_i.sh)
      SH_FRAC1: res_o = r_frac1[OPW-1:0];
      SH_16:    res_o = r_16[OPW-1:0];
      default:  res_o = r_frac[OPW-1:0];
    endcase
  end

endmodule

### rtl/mlp_backprop_trainer_2_2_1.sv
`timescale 1ns / 1ps
// Top level of the 2-2-1 sigmoid perceptron trainer (batch backpropagation).
// Depends on mbt_pkg and mbt_mul.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one training sample per
//   request: two Q3.12 inputs, a Q1.12 target, batch_end and restart.
//   Output channel (out_valid_o / out_ready_i) returns one result per sample:
//   network output, half squared error, running batch error and a flag that
//   tells whether the weights were updated after this sample.
//   The sequencer works on one sample at a time. Every multiply of the forward
//   and backward pass runs on one shared multiplier, one per cycle, and the five
//   sigmoid lookups go through one table port, in a fixed sequence.
//   in_ready_o is high only while the sequencer is idle. A finished result
//   sits in the output register; the next request may be taken meanwhile,
//   and its result waits at the last step until the output register frees.
//   Reset: weights take the init register reset values, delta sums and the
//   error sum clear, no result is pending.
//   Configuration: write registers through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while idle; index 0 is the learning rate, 1..6 the initial weights.
module mlp_backprop_trainer_2_2_1 #(
  parameter int FRAC_BITS       = 12,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mbt_pkg::CIW-1:0]      cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [15:0]           sample_a_i,
  input  logic signed [15:0]           sample_b_i,
  input  logic [12:0]                  target_value_i,
  input  logic                         batch_end_i,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [12:0]                  net_output_o,
  output logic [11:0]                  sample_error_o,
  output logic [15:0]                  batch_error_o,
  output logic                         weights_updated_o
);
  import mbt_pkg::*;

  localparam int KW = $clog2(SIGMOID_ENTRIES);
  localparam logic signed [OPW-1:0] One = OPW'(1) <<< FRAC_BITS;
  localparam logic signed [15:0] InitW [NW] = '{16'sd2048, -16'sd1638, -16'sd1229,
                                                16'sd3277, 16'sd1434, -16'sd2458};

  typedef logic [FRAC_BITS:0] lut_arr_t [SIGMOID_ENTRIES];

  function automatic lut_arr_t build_lut();
    lut_arr_t t;
    for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
      t[k] = (FRAC_BITS + 1)'(sig_entry(longint'(k), longint'(SIGMOID_ENTRIES),
                                        longint'(FRAC_BITS)));
    end
    return t;
  endfunction

  localparam lut_arr_t SigLut = build_lut();

  // Sequencer and working registers
  step_e step_q, step_d;

  logic [15:0]              lr_q;
  logic signed [15:0]       init_q [NW];
  logic signed [15:0]       w_q [NW];
  logic signed [DLW-1:0]    dl_q [NW];
  logic [15:0]              err_q;

  logic signed [15:0]       a_q, b_q;
  logic signed [OPW-1:0]    tgt_q;
  logic                     be_q;
  logic signed [OPW-1:0]    x0_q, x1_q, h0_q, h1_q, o_q, g_q, hs_q, v_q;
  logic signed [PW-1:0]     acc_q;
  logic [11:0]              se_q;
  logic [15:0]              berr_q;

  logic                     out_valid_q;
  logic [12:0]              net_output_q;
  logic [11:0]              sample_error_q;
  logic [15:0]              batch_error_q;
  logic                     weights_updated_q;

  // Shared multiplier
  mul_req_t                 mreq;
  logic signed [PW-1:0]     prod;
  logic signed [OPW-1:0]    mres;

  mbt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .req_i  (mreq),
    .prod_o (prod),
    .res_o  (mres)
  );

  // Sigmoid lookup: saturate, pick slice, read table
  logic signed [PW-1:0]     acc_rnd;
  logic signed [15:0]       acc_sat;
  logic signed [15:0]       lut_x;
  logic [31:0]              lut_scaled;
  logic [KW-1:0]            lut_k;
  logic signed [OPW-1:0]    sig_val;
  logic signed [OPW-1:0]    diff;
  logic [2:0]               didx;
  logic                     start;
  logic                     fin;

  assign acc_rnd = (acc_q + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign acc_sat = (acc_rnd > PW'(32767))  ? 16'sh7fff :
                   (acc_rnd < -PW'(32768)) ? 16'sh8000 : acc_rnd[15:0];

  always_comb begin
    case (step_q)
      ST_X0:   lut_x = a_q;
      ST_X1:   lut_x = b_q;
      default: lut_x = acc_sat;
    endcase
  end

  assign lut_scaled = 32'({~lut_x[15], lut_x[14:0]}) * 32'(SIGMOID_ENTRIES);
  assign lut_k      = lut_scaled[16 +: KW];
  assign sig_val    = OPW'(SigLut[lut_k]);
  assign diff       = o_q - tgt_q;

  assign start = in_valid_i && in_ready_o;
  assign fin   = (step_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer: operand select and next step
  always_comb begin
    mreq.opa = diff;
    mreq.opb = diff;
    mreq.sh  = SH_FRAC;
    didx     = 3'd0;
    step_d   = step_q;
    case (step_q)
      ST_IDLE: if (in_valid_i) step_d = ST_X0;
      ST_X0:   step_d = ST_X1;
      ST_X1:   step_d = ST_H0A;
      ST_H0A: begin
        mreq.opa = x0_q; mreq.opb = OPW'(w_q[0]); step_d = ST_H0B;
      end
      ST_H0B: begin
        mreq.opa = x1_q; mreq.opb = OPW'(w_q[1]); step_d = ST_H0S;
      end
      ST_H0S:  step_d = ST_H1A;
      ST_H1A: begin
        mreq.opa = x0_q; mreq.opb = OPW'(w_q[2]); step_d = ST_H1B;
      end
      ST_H1B: begin
        mreq.opa = x1_q; mreq.opb = OPW'(w_q[3]); step_d = ST_H1S;
      end
      ST_H1S:  step_d = ST_OA;
      ST_OA: begin
        mreq.opa = h0_q; mreq.opb = OPW'(w_q[4]); step_d = ST_OB;
      end
      ST_OB: begin
        mreq.opa = h1_q; mreq.opb = OPW'(w_q[5]); step_d = ST_OS;
      end
      ST_OS:   step_d = ST_SE;
      ST_SE: begin
        mreq.sh = SH_FRAC1; step_d = ST_G1;
      end
      ST_G1: begin
        mreq.opb = o_q; step_d = ST_G2;
      end
      ST_G2: begin
        mreq.opa = hs_q; mreq.opb = One - o_q; step_d = ST_A4V;
      end
      ST_A4V: begin
        mreq.opa = g_q; mreq.opb = h0_q; step_d = ST_A4D;
      end
      ST_A5V: begin
        mreq.opa = g_q; mreq.opb = h1_q; step_d = ST_A5D;
      end
      ST_J0W: begin
        mreq.opa = g_q; mreq.opb = OPW'(w_q[4]); step_d = ST_J0H;
      end
      ST_J0H: begin
        mreq.opa = hs_q; mreq.opb = h0_q; step_d = ST_J0D;
      end
      ST_J0D: begin
        mreq.opa = hs_q; mreq.opb = One - h0_q; step_d = ST_A0V;
      end
      ST_A0V: begin
        mreq.opa = hs_q; mreq.opb = x0_q; step_d = ST_A0D;
      end
      ST_A1V: begin
        mreq.opa = hs_q; mreq.opb = x1_q; step_d = ST_A1D;
      end
      ST_J1W: begin
        mreq.opa = g_q; mreq.opb = OPW'(w_q[5]); step_d = ST_J1H;
      end
      ST_J1H: begin
        mreq.opa = hs_q; mreq.opb = h1_q; step_d = ST_J1D;
      end
      ST_J1D: begin
        mreq.opa = hs_q; mreq.opb = One - h1_q; step_d = ST_A2V;
      end
      ST_A2V: begin
        mreq.opa = hs_q; mreq.opb = x0_q; step_d = ST_A2D;
      end
      ST_A3V: begin
        mreq.opa = hs_q; mreq.opb = x1_q; step_d = ST_A3D;
      end
      ST_A4D, ST_A5D, ST_A0D, ST_A1D, ST_A2D, ST_A3D: begin
        // delta = round(-(rate * v) / 2^16)
        mreq.opa = -OPW'(lr_q);
        mreq.opb = v_q;
        mreq.sh  = SH_16;
        case (step_q)
          ST_A4D: begin didx = 3'd4; step_d = ST_A5V; end
          ST_A5D: begin didx = 3'd5; step_d = ST_J0W; end
          ST_A0D: begin didx = 3'd0; step_d = ST_A1V; end
          ST_A1D: begin didx = 3'd1; step_d = ST_J1W; end
          ST_A2D: begin didx = 3'd2; step_d = ST_A3V; end
          default: begin didx = 3'd3; step_d = ST_UPD; end
        endcase
      end
      ST_UPD:  step_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) step_d = ST_IDLE;
      default: step_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (step_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // Configuration, weights, sums and working registers
  logic signed [DLW:0]  dl_sum;
  logic [17:0]          err_sum;
  logic signed [DLW:0]  w_sum [NW];

  assign dl_sum  = (DLW+1)'(dl_q[didx]) + (DLW+1)'(mres);
  assign err_sum = 18'(err_q) + 18'(mres[16:0]);

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      w_sum[i] = (DLW+1)'(w_q[i]) + (DLW+1)'(dl_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= 16'd1966;
      err_q <= '0;
      for (int i = 0; i < NW; i++) begin
        init_q[i] <= InitW[i];
        w_q[i]    <= InitW[i];
        dl_q[i]   <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LEARN_RATE) begin
          lr_q <= cfg_wdata_i;
        end else if (cfg_idx_i <= REG_INIT_LAST) begin
          init_q[cfg_idx_i - 3'd1] <= cfg_wdata_i;
        end
      end
      // restart: reload weights and clear sums before the sample
      if (start && restart_i) begin
        err_q <= '0;
        for (int i = 0; i < NW; i++) begin
          w_q[i]  <= init_q[i];
          dl_q[i] <= '0;
        end
      end
      case (step_q)
        ST_SE: begin
          err_q <= err_sum[17:16] != 2'b00 ? 16'hffff : err_sum[15:0];
        end
        ST_A4D, ST_A5D, ST_A0D, ST_A1D, ST_A2D, ST_A3D: begin
          if (dl_sum > (DLW+1)'(8388607)) dl_q[didx] <= 24'sh7fffff;
          else if (dl_sum < -(DLW+1)'(8388608)) dl_q[didx] <= 24'sh800000;
          else dl_q[didx] <= dl_sum[DLW-1:0];
        end
        ST_UPD: begin
          if (be_q) begin
            err_q <= '0;
            for (int i = 0; i < NW; i++) begin
              dl_q[i] <= '0;
              if (w_sum[i] > (DLW+1)'(32767)) w_q[i] <= 16'sh7fff;
              else if (w_sum[i] < -(DLW+1)'(32768)) w_q[i] <= 16'sh8000;
              else w_q[i] <= w_sum[i][15:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; no reset needed
  always_ff @(posedge clk_i) begin
    if (start) begin
      a_q   <= sample_a_i;
      b_q   <= sample_b_i;
      be_q  <= batch_end_i;
      // clamp target to one
      tgt_q <= (OPW'(target_value_i) > One) ? One : OPW'(target_value_i);
    end
    case (step_q)
      ST_X0:  x0_q  <= sig_val;
      ST_X1:  x1_q  <= sig_val;
      ST_H0A, ST_H1A, ST_OA: acc_q <= prod;
      ST_H0B, ST_H1B, ST_OB: acc_q <= acc_q + prod;
      ST_H0S: h0_q  <= sig_val;
      ST_H1S: h1_q  <= sig_val;
      ST_OS:  o_q   <= sig_val;
      ST_SE: begin
        se_q   <= mres[11:0];
        berr_q <= err_sum[17:16] != 2'b00 ? 16'hffff : err_sum[15:0];
      end
      ST_G1, ST_J0W, ST_J0H, ST_J0D, ST_J1W, ST_J1H, ST_J1D: hs_q <= mres;
      ST_G2:  g_q   <= mres;
      ST_A4V, ST_A5V, ST_A0V, ST_A1V, ST_A2V, ST_A3V: v_q <= mres;
      default: ;
    endcase
  end

  // Output register: hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      net_output_q      <= o_q[12:0];
      sample_error_q    <= se_q;
      batch_error_q     <= berr_q;
      weights_updated_q <= be_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign net_output_o      = net_output_q;
  assign sample_error_o    = sample_error_q;
  assign batch_error_o     = batch_error_q;
  assign weights_updated_o = weights_updated_q;

endmodule

### verif/mbt_checker.sv
`timescale 1ns / 1ps
// Result checker for the 2-2-1 backpropagation trainer: tracks configuration
// writes, predicts each result from accepted requests and compares them.
// Depends on mbt_pkg for the register index width and codes.
module mbt_checker (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [mbt_pkg::CIW-1:0] cfg_idx_i,
  input  logic [15:0]             cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic signed [15:0]      sample_a_i,
  input  logic signed [15:0]      sample_b_i,
  input  logic [12:0]             target_value_i,
  input  logic                    batch_end_i,
  input  logic                    restart_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [12:0]             net_output_i,
  input  logic [11:0]             sample_error_i,
  input  logic [15:0]             batch_error_i,
  input  logic                    weights_updated_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o,
  output int                      updates_o
);
  import mbt_pkg::*;

  localparam int TBL = 256;
  localparam longint ONE = 4096;
  localparam longint Q30 = longint'(1) << 30;

  typedef struct {
    logic [12:0] net;
    logic [11:0] serr;
    logic [15:0] berr;
    logic        upd;
  } train_result_t;

  train_result_t result_q[$];
  longint sig_tbl[TBL];
  longint rate;
  longint init_wt[NW];
  longint wt[NW];
  longint dsum[NW];
  longint esum;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Round half up after dropping s fraction bits.
  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // exp(-t) in Q30: series on the fraction, then one exp(-1) per whole unit.
  function automatic longint exp_down(longint t30);
    longint fr, whole, acc, term;
    fr = t30 & (Q30 - 1);
    whole = t30 >> 30;
    acc = Q30;
    term = Q30;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * fr) >> 30) / n;
      acc = (n % 2 == 1) ? acc - term : acc + term;
    end
    repeat (whole) acc = (acc * 395007542 + (Q30 >> 1)) >> 30;
    return acc;
  endfunction

  function automatic longint sig(longint x);
    longint slot;
    slot = ((clip(x, -32768, 32767) + 32768) * TBL) >> 16;
    return sig_tbl[clip(slot, 0, TBL - 1)];
  endfunction

  task automatic clear_train(bit reload);
    for (int i = 0; i < NW; i++) begin
      if (reload) wt[i] = init_wt[i];
      dsum[i] = 0;
    end
    esum = 0;
  endtask

  task automatic regs_default();
    rate = 1966;
    init_wt = '{2048, -1638, -1229, 3277, 1434, -2458};
    clear_train(1'b1);
  endtask

  task automatic add_delta(int idx, longint grad, longint act);
    longint v, d;
    v = rnd(grad * act, 12);
    d = rnd(-(rate * v), 16);
    dsum[idx] = clip(dsum[idx] + d, -8388608, 8388607);
  endtask

  task automatic train_step(longint a, longint b, longint tv, bit fin, bit rst);
    longint x[2], h[2], o, t, diff, se, g, hs;
    train_result_t r;
    if (rst) clear_train(1'b1);
    x[0] = sig(a);
    x[1] = sig(b);
    t = (tv > ONE) ? ONE : tv;
    for (int j = 0; j < 2; j++) h[j] = sig(rnd(x[0] * wt[2*j] + x[1] * wt[2*j+1], 12));
    o = sig(rnd(h[0] * wt[4] + h[1] * wt[5], 12));
    diff = o - t;
    se = rnd(diff * diff, 13);
    esum = clip(esum + se, 0, 65535);
    g = rnd(rnd(diff * o, 12) * (ONE - o), 12);
    add_delta(4, g, h[0]);
    add_delta(5, g, h[1]);
    // hidden gradients use the weights of this batch, before any update
    for (int j = 0; j < 2; j++) begin
      hs = rnd(g * wt[4+j], 12);
      hs = rnd(rnd(hs * h[j], 12) * (ONE - h[j]), 12);
      add_delta(2*j, hs, x[0]);
      add_delta(2*j+1, hs, x[1]);
    end
    r.net = o[12:0];
    r.serr = se[11:0];
    r.berr = esum[15:0];
    r.upd = fin;
    result_q.push_back(r);
    if (fin) begin
      for (int i = 0; i < NW; i++) wt[i] = clip(wt[i] + dsum[i], -32768, 32767);
      clear_train(1'b0);
    end
  endtask

  task automatic report(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    longint c, e;
    fail_count_o = 0;
    checked_o = 0;
    updates_o = 0;
    for (int k = 0; k < TBL; k++) begin
      c = ((2 * k + 1) * 65536) / (2 * TBL) - 32768;
      e = exp_down(((c < 0) ? -c : c) << 18);
      sig_tbl[k] = (((c >= 0) ? ONE * Q30 : ONE * e) + (Q30 + e) / 2) / (Q30 + e);
    end
    regs_default();
  end

  assign pending_o = result_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    train_result_t w;
    if (!rst_ni) begin
      regs_default();
      result_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LEARN_RATE) rate = cfg_wdata_i;
        else if (cfg_idx_i <= REG_INIT_LAST)
          init_wt[cfg_idx_i - 1] = longint'($signed(cfg_wdata_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          fail_count_o++;
        end else begin
          w = result_q.pop_front();
          checked_o++;
          if (weights_updated_i) updates_o++;
          if (net_output_i !== w.net) report("net_output", net_output_i, w.net);
          if (sample_error_i !== w.serr) report("sample_error", sample_error_i, w.serr);
          if (batch_error_i !== w.berr) report("batch_error", batch_error_i, w.berr);
          if (weights_updated_i !== w.upd)
            report("weights_updated", weights_updated_i, w.upd);
        end
      end
      if (in_valid_i && in_ready_i)
        train_step(sample_a_i, sample_b_i, target_value_i, batch_end_i, restart_i);
    end
  end

endmodule

### verif/mlp_backprop_trainer_2_2_1_test.sv
`timescale 1ns / 1ps
// Top of the trainer testbench: clock, reset, sample stimulus, receiver
// stalls, watchdog and verdict. Depends on mbt_pkg, mbt_checker and the RTL.
module mlp_backprop_trainer_2_2_1_test;
  import mbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 300;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CIW-1:0]       cfg_idx_i = '0;
  logic [15:0]          cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [15:0]   sample_a_i = '0;
  logic signed [15:0]   sample_b_i = '0;
  logic [12:0]          target_value_i = '0;
  logic                 batch_end_i = 1'b0;
  logic                 restart_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [12:0]          net_output_o;
  logic [11:0]          sample_error_o;
  logic [15:0]          batch_error_o;
  logic                 weights_updated_o;

  int fail_count, pending, checked, updates;
  int sent = 0;
  int idle_cycles = 0;

  mlp_backprop_trainer_2_2_1 uut (.*);

  mbt_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .sample_a_i, .sample_b_i,
    .target_value_i, .batch_end_i, .restart_i,
    .out_valid_i(out_valid_o), .out_ready_i, .net_output_i(net_output_o),
    .sample_error_i(sample_error_o), .batch_error_i(batch_error_o),
    .weights_updated_i(weights_updated_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .updates_o(updates)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: switch stall mode now and then - always ready, coin flip,
  // or mostly ready with an occasional long stall.
  int stall_mode = 0, mode_left = 0, stall_left = 0;
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(100, 600);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready_i <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(5, 40);
        end
      endcase
    end
  end

  // Watchdog: no acceptance on either channel for too long ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sender burst state.
  int burst_left = 0;

  // Hold one request until accepted, then drop valid if a gap follows.
  task automatic send_sample(logic [15:0] a, logic [15:0] b, logic [12:0] tv,
                             bit fin, bit rst);
    int gap;
    sample_a_i     <= a;
    sample_b_i     <= b;
    target_value_i <= tv;
    batch_end_i    <= fin;
    restart_i      <= rst;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Wait for every result, then let the sequencer settle.
  task automatic drain();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly mid-range inputs so the sigmoid sees its whole curve, a few full-scale.
  function automatic logic [15:0] rand_input();
    if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
    return 16'($signed($urandom_range(0, 32767)) - 16384);
  endfunction

  function automatic logic [12:0] rand_target();
    if ($urandom_range(0, 9) == 0) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(0, 4096));
  endfunction

  // Random training: mostly whole batches, the first from a restart, some noise samples.
  task automatic train_random(int n);
    int left, bsz;
    bit first;
    left  = n;
    first = 1'b1;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_sample(rand_input(), rand_input(), rand_target(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        left--;
      end else begin
        bsz = $urandom_range(1, 8);
        for (int i = 0; i < bsz && left > 0; i++) begin
          send_sample(rand_input(), rand_input(), rand_target(),
                      (i == bsz - 1), first && (i == 0));
          left--;
        end
        first = ($urandom_range(0, 15) == 0);
      end
    end
  endtask

  initial begin
    logic [15:0] extremes[3];
    extremes = '{16'h8000, 16'h7FFF, 16'h0000};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, targets above one, restart and batch end.
    foreach (extremes[i])
      foreach (extremes[j])
        send_sample(extremes[i], extremes[j], 13'd4096, 1'b0, 1'b0);
    send_sample(16'h1000, 16'hF000, 13'd0, 1'b1, 1'b0);
    send_sample(16'h0800, 16'h0800, 13'd4097, 1'b0, 1'b1);
    send_sample(16'hFFFF, 16'h0001, 13'd8191, 1'b1, 1'b0);
    send_sample(16'h2000, 16'hE000, 13'd2048, 1'b1, 1'b1);

    // Pause until every result is back before continuing.
    drain();
    train_random(PHASE_ITEMS);
    drain();

    // Wide sums and fast learning: extreme init weights and full rate.
    write_reg(REG_LEARN_RATE, 16'hFFFF);
    for (int r = 1; r <= REG_INIT_LAST; r++)
      write_reg(CIW'(r), (r % 2) ? 16'h7FFF : 16'h8000);
    write_reg(3'd7, 16'h1234);  // unknown index, must be ignored
    send_sample(16'h7FFF, 16'h7FFF, 13'd0, 1'b0, 1'b1);
    train_random(PHASE_ITEMS);
    drain();

    // Frozen weights: zero learning rate, opposite extremes.
    write_reg(REG_LEARN_RATE, 16'h0000);
    for (int r = 1; r <= REG_INIT_LAST; r++)
      write_reg(CIW'(r), (r % 2) ? 16'h8000 : 16'h7FFF);
    train_random(PHASE_ITEMS);
    drain();

    // Random settings for the rest.
    repeat (3) begin
      for (int r = 0; r <= 7; r++) write_reg(CIW'(r), 16'($urandom_range(0, 65535)));
      train_random(PHASE_ITEMS);
      drain();
    end

    // A long batch with a high rate to push the delta and error sums to the rails.
    write_reg(REG_LEARN_RATE, 16'hF000);
    for (int i = 0; i < 60; i++)
      send_sample(rand_input(), rand_input(), (i % 2) ? 13'd0 : 13'd4096,
                  (i == 59), (i == 0));
    drain();

    $display("Sent %0d samples, checked %0d results, %0d weight updates,",
             sent, checked, updates);
    $display("across default, extreme, frozen and random register settings.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
